// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Checks an overlapping implication at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks a next-cycle implication at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbm_pkg;

    // Field widths of one transaction on either channel.
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 32;
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 56;
    localparam int BYTE_BITS    = 8;
    localparam int LANES        = 4;

    typedef logic [1:0] trap_cause_t;

    // Action codes.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    // Access size codes; the unused code behaves as a word.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Trap causes.
    localparam trap_cause_t CAUSE_NONE             = 2'd0;
    localparam trap_cause_t CAUSE_LOAD_MISALIGNED  = 2'd1;
    localparam trap_cause_t CAUSE_LOAD_FAULT       = 2'd2;
    localparam trap_cause_t CAUSE_STORE_MISALIGNED = 2'd3;

    // Byte-lane mask for an access of the given size at the given lane.
    function automatic logic [LANES-1:0] lane_mask(input logic [1:0] size,
                                                   input logic [1:0] lane);
        logic [LANES-1:0] m;
        case (size)
            SIZE_BYTE: m = 4'b0001 << lane;
            SIZE_HALF: m = 4'b0011 << lane;
            default:   m = 4'b1111;
        endcase
        return m;
    endfunction

    // Expands a byte-lane mask to a bit mask.
    function automatic logic [DATA_W-1:0] bit_mask(input logic [LANES-1:0] m);
        logic [DATA_W-1:0] b;
        for (int i = 0; i < LANES; i++) begin
            b[i*BYTE_BITS +: BYTE_BITS] = {BYTE_BITS{m[i]}};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pbm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbm_ram #(
    parameter int AW = 14,
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(2**AW)-1];
    logic [DW-1:0] rdata_reg;

    // Single port: a write or a registered read each cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/paged_byte_memory_with_traps_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Paged byte memory with traps, little-endian.
// The s_ channel carries one access per transaction: a load or store of a
// byte, halfword or word. The m_ channel returns one result per access: the
// zero-extended load data, the trap cause and the trapping address.
// Misaligned halfword and word accesses trap and change nothing. A store
// marks its page as touched; a load from an untouched page traps with a load
// fault. Data and trap address are zero where the access gives none.
// The result passes through the read stage and the output register before
// m_tvalid rises. s_tready is low while the read stage holds an access, so
// a new access is taken only once the last one has left the read stage;
// the single-port data RAM reads at acceptance and takes a store's write-back
// as it leaves the read stage. Reset: aresetn clears the page flags at once
// and starts a clearing pass that writes zero to every RAM word, one word per
// cycle; s_tready stays low during the pass. A stalled m_ channel holds its
// result; one more access may be taken and waits in the read stage until
// the output register is free.
module paged_byte_memory_with_traps_top #(
    parameter int ADDR_BITS = 16,
    parameter int PAGE_BITS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] action, [2:1] access_size, [18:3] address, [50:19] store_data
    input  wire logic [pbm_pkg::S_TDATA_W-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] load_data, [33:32] trap_cause, [49:34] trap_address
    output logic [pbm_pkg::M_TDATA_W-1:0] m_tdata
);

    import pbm_pkg::*;

`include "assert_macros.svh"

    // Address bits that can reach the memory.
    localparam int EFF_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int WIDX_BITS = EFF_BITS - 2;
    localparam int PIDX_BITS = (EFF_BITS > PAGE_BITS) ? (EFF_BITS - PAGE_BITS) : 1;
    localparam int PAGES     = 2 ** PIDX_BITS;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS);

    // Input field split.
    logic              in_action;
    logic [1:0]        in_size;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_sdata;
    logic              in_misaligned;

    assign in_action = s_tdata[0];
    assign in_size   = s_tdata[2:1];
    assign in_addr   = s_tdata[18:3] & ADDR_MASK;
    assign in_sdata  = s_tdata[50:19];

    always_comb begin
        case (in_size)
            SIZE_BYTE: in_misaligned = 1'b0;
            SIZE_HALF: in_misaligned = in_addr[0];
            default:   in_misaligned = (in_addr[1:0] != 2'b00);
        endcase
    end

    // Clearing pass state.
    logic                 clr_busy_reg, clr_busy_next;
    logic [WIDX_BITS-1:0] clr_addr_reg, clr_addr_next;

    // Read stage state.
    logic              p1_valid_reg, p1_valid_next;
    logic              p1_action_reg;
    logic [1:0]        p1_size_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [DATA_W-1:0] p1_sdata_reg;
    logic              p1_mis_reg;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_ldata_reg;
    trap_cause_t       m_cause_reg;
    logic [ADDR_W-1:0] m_taddr_reg;

    logic [PAGES-1:0]  page_reg, page_next;

    logic              s_accept;
    logic              advance;

    assign s_tready = !clr_busy_reg && !p1_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign advance  = p1_valid_reg && (!m_valid_reg || m_tready);

    // Read-stage decode.
    logic [1:0]           p1_lane;
    logic [WIDX_BITS-1:0] p1_widx;
    logic [PIDX_BITS-1:0] p1_pidx;
    logic [ADDR_W-1:0]    p1_page_shift;
    logic [DATA_W-1:0]    rd_word;
    logic [DATA_W-1:0]    wmask;
    logic [DATA_W-1:0]    merged;
    logic [DATA_W-1:0]    shifted_load;
    logic [DATA_W-1:0]    res_ldata;
    trap_cause_t          res_cause;
    logic [ADDR_W-1:0]    res_taddr;
    logic                 do_store;

    assign p1_lane       = p1_addr_reg[1:0];
    assign p1_widx       = p1_addr_reg[EFF_BITS-1:2];
    assign p1_page_shift = p1_addr_reg >> PAGE_BITS;
    assign p1_pidx       = p1_page_shift[PIDX_BITS-1:0];

    // Merge store bytes into the word read back; extract load bytes.
    always_comb begin
        wmask        = bit_mask(lane_mask(p1_size_reg, p1_lane));
        merged       = (rd_word & ~wmask)
                       | ((p1_sdata_reg << (p1_lane * 5'(BYTE_BITS))) & wmask);
        shifted_load = rd_word >> (p1_lane * 5'(BYTE_BITS));
    end

    // Result selection.
    always_comb begin
        res_ldata = '0;
        res_cause = CAUSE_NONE;
        res_taddr = '0;
        do_store  = 1'b0;
        if (p1_mis_reg) begin
            res_cause = (p1_action_reg == ACT_STORE) ? CAUSE_STORE_MISALIGNED
                                                     : CAUSE_LOAD_MISALIGNED;
            res_taddr = p1_addr_reg;
        end else if (p1_action_reg == ACT_STORE) begin
            do_store = 1'b1;
        end else if (!page_reg[p1_pidx]) begin
            res_cause = CAUSE_LOAD_FAULT;
            res_taddr = p1_addr_reg;
        end else begin
            case (p1_size_reg)
                SIZE_BYTE: res_ldata = {24'd0, shifted_load[7:0]};
                SIZE_HALF: res_ldata = {16'd0, shifted_load[15:0]};
                default:   res_ldata = shifted_load;
            endcase
        end
    end

    // RAM port: clearing pass, store write-back, or read at acceptance.
    logic                 ram_en, ram_we;
    logic [WIDX_BITS-1:0] ram_addr;
    logic [DATA_W-1:0]    ram_wdata;

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = in_addr[EFF_BITS-1:2];
        ram_wdata = merged;
        if (clr_busy_reg) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end else if (advance && do_store) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = p1_widx;
        end else if (s_accept) begin
            ram_en = 1'b1;
        end
    end

    pbm_ram #(
        .AW(WIDX_BITS),
        .DW(DATA_W)
    ) u_ram (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(rd_word)
    );

    // Next-state logic for control.
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {WIDX_BITS{1'b1}}) begin
                clr_busy_next = 1'b0;
            end
        end

        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        page_next = page_reg;
        if (advance && do_store) begin
            page_next[p1_pidx] = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            page_reg     <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            page_reg     <= page_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_action_reg <= in_action;
            p1_size_reg   <= in_size;
            p1_addr_reg   <= in_addr;
            p1_sdata_reg  <= in_sdata;
            p1_mis_reg    <= in_misaligned;
        end
        if (advance) begin
            m_ldata_reg <= res_ldata;
            m_cause_reg <= res_cause;
            m_taddr_reg <= res_taddr;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_taddr_reg, m_cause_reg, m_ldata_reg};

    // Checks.
    `ASSERT_IMPLIES(a_clear_quiet, aclk, aresetn, clr_busy_reg,
        !p1_valid_reg && !m_valid_reg, "Activity during the clearing pass.")
    `ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_accept,
        p1_valid_reg && p1_addr_reg == $past(in_addr), "Accepted access not staged.")
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, p1_valid_reg && !advance,
        p1_valid_reg && $stable(p1_addr_reg), "Staged access lost under stall.")
    `ASSERT_IMPLIES(a_trap_no_data, aclk, aresetn,
        m_valid_reg && m_cause_reg != CAUSE_NONE, m_ldata_reg == '0,
        "Trap result carries load data.")
    `ASSERT_IMPLIES(a_clean_no_taddr, aclk, aresetn,
        m_valid_reg && m_cause_reg == CAUSE_NONE, m_taddr_reg == '0,
        "Trap address set without a trap.")

endmodule

`default_nettype wire
